[rtl/pms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants for the periodic message scheduler.
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int MAX_USERS = 64;
    localparam int IDX_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CNT_W     = $clog2(MAX_USERS + 1);
    localparam int ID_W      = 16;
    localparam int PER_W     = 16;
    localparam int TIME_W    = 48;
    localparam int ENTRY_W   = ID_W + PER_W + TIME_W;

    typedef enum logic [1:0] {
        ACT_REG   = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_SAT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FREE_SCAN,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    scan_start;
        logic    scan_step;
        logic    write_reg;
        logic    reinsert;
        logic    clear_all;
        logic    res_set;
        t_status res_status;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    full;
        logic    empty;
        logic    slot_free;
        logic    idx_last;
        logic    out_free;
    } t_sts;

endpackage

[rtl/pms_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: dispatches each transaction and steps the slot scans.
// ----------------------------------------------------------------------------
module pms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pms_pkg::t_sts i_sts,
    output pms_pkg::t_cmd o_cmd
);
    import pms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = STAT_OK;
                n_state          = S_RESULT;
                unique case (i_sts.act)
                    ACT_REG: begin
                        if (i_sts.full) begin
                            o_cmd.res_status = STAT_FULL;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_FREE_SCAN;
                        end
                    end
                    ACT_NEXT: begin
                        if (i_sts.empty) begin
                            o_cmd.res_status = STAT_EMPTY;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                    end
                    default: begin
                        o_cmd.res_status = STAT_OK;
                    end
                endcase
            end
            S_FREE_SCAN: begin
                if (i_sts.slot_free) begin
                    o_cmd.write_reg = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.reinsert = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/pms_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_dp
// Entry memory, valid bits, minimum search and the result register.
// ----------------------------------------------------------------------------
module pms_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pms_pkg::t_cmd          i_cmd,
    output pms_pkg::t_sts          o_sts,
    input  logic [1:0]             i_action,
    input  logic [15:0]            i_user_id,
    input  logic [15:0]            i_period,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [15:0]            o_sent_id,
    output logic [47:0]            o_send_time
);
    import pms_pkg::*;

    // captured transaction
    t_action            r_act;
    logic [ID_W-1:0]    r_uid;
    logic [PER_W-1:0]   r_per;

    logic [ENTRY_W-1:0] r_mem [MAX_USERS];
    logic [MAX_USERS-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;

    // read pipeline
    logic [ENTRY_W-1:0] r_rd_data;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_pend;
    logic               r_rd_vld;

    // best candidate
    logic               r_best_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [ID_W-1:0]    r_best_id;
    logic [PER_W-1:0]   r_best_per;
    logic [TIME_W-1:0]  r_best_time;

    // pending result
    t_status            r_res_status;
    logic [ID_W-1:0]    r_res_id;
    logic [TIME_W-1:0]  r_res_time;

    logic               r_o_valid;
    t_status            r_o_status;
    logic [ID_W-1:0]    r_o_id;
    logic [TIME_W-1:0]  r_o_time;

    logic [ID_W-1:0]    rd_id;
    logic [TIME_W-1:0]  rd_time;
    logic               take;
    logic [TIME_W:0]    sum;
    logic               sat;
    logic [TIME_W-1:0]  new_time;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;

    assign rd_id   = r_rd_data[ENTRY_W-1 -: ID_W];
    assign rd_time = r_rd_data[TIME_W-1:0];

    // keep the earliest time, ties to the smaller id, then lower slot
    assign take = r_rd_pend && r_rd_vld &&
                  (!r_best_found || (rd_time < r_best_time) ||
                   ((rd_time == r_best_time) && (rd_id < r_best_id)));

    assign sum      = {1'b0, r_best_time} + (TIME_W + 1)'(r_best_per);
    assign sat      = sum[TIME_W];
    assign new_time = sat ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_comb begin
        we    = i_cmd.write_reg || i_cmd.reinsert;
        waddr = r_idx;
        wdata = {r_uid, r_per, (TIME_W)'(r_per)};
        if (i_cmd.reinsert) begin
            waddr = r_best_idx;
            wdata = {r_best_id, r_best_per, new_time};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act <= t_action'(i_action);
            r_uid <= i_user_id;
            r_per <= i_period;
        end
        r_rd_idx <= r_idx;
        r_rd_vld <= r_valid[r_idx];
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (take) begin
            r_best_idx  <= r_rd_idx;
            r_best_id   <= rd_id;
            r_best_per  <= r_rd_data[TIME_W +: PER_W];
            r_best_time <= rd_time;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_id     <= '0;
            r_res_time   <= '0;
        end else if (i_cmd.reinsert) begin
            r_res_status <= sat ? STAT_SAT : STAT_OK;
            r_res_id     <= r_best_id;
            r_res_time   <= r_best_time;
        end
        if (i_cmd.res_load) begin
            r_o_status <= r_res_status;
            r_o_id     <= r_res_id;
            r_o_time   <= r_res_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_count      <= '0;
            r_rd_pend    <= 1'b0;
            r_best_found <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_step && (r_act == ACT_NEXT);
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_count <= '0;
            end else if (i_cmd.write_reg) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_best_found <= 1'b0;
            end else if (take) begin
                r_best_found <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.act       = r_act;
        o_sts.full      = (r_count == CNT_W'(MAX_USERS));
        o_sts.empty     = (r_count == '0);
        o_sts.slot_free = !r_valid[r_idx];
        o_sts.idx_last  = (r_idx == IDX_W'(MAX_USERS - 1));
        o_sts.out_free  = !r_o_valid || i_out_ready;
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_sent_id   = r_o_id;
    assign o_send_time = r_o_time;

endmodule

[rtl/periodic_message_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_message_scheduler_top
// Periodic scheduler holding up to MAX_USERS users in a slot memory.
//
//   channel | direction | signals                                 | handshake
//   input   | in        | i_action, i_user_id, i_period           | i_in_valid / o_in_ready
//   output  | out       | o_status, o_sent_id, o_send_time        | o_out_valid / i_out_ready
//
// One transaction at a time. Register scans upward for the lowest free slot;
// next scans all MAX_USERS slots: one slot memory read per cycle feeds the
// earliest-time compare. Clear and full/empty cases skip the slot scans.
// Reset clears all valid bits and the entry count.
// A result waits in the output register while the next transaction is
// accepted; the sequencer stalls only when it must load a second result.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_user_id,
    input  logic [15:0] i_period,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_sent_id,
    output logic [47:0] o_send_time
);
    import pms_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    pms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_action),
        .i_user_id   (i_user_id),
        .i_period    (i_period),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_sent_id   (o_sent_id),
        .o_send_time (o_send_time)
    );

    // an empty or full report never carries an id or time
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_EMPTY || o_status == STAT_FULL))
        |-> (o_sent_id == '0 && o_send_time == '0))
        else $error("empty/full result carries payload");

    // one transaction in flight: ready drops after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while busy");

    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule
